@@ design/aes_block_cipher_unit_assert.svh @@
// Assertion macros used by the checker file of the cipher unit.
`ifndef AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Next-cycle implication, masked while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset too.
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aesbc_pkg.sv @@
// Shared types, constants and byte-level functions of the AES cipher unit.
package aesbc_pkg;

    localparam int NUM_RND = 14;

    typedef enum logic [2:0] {
        CFG_KEY_SIZE  = 3'd0,
        CFG_KEY_WORD0 = 3'd1,
        CFG_KEY_WORD1 = 3'd2,
        CFG_KEY_WORD2 = 3'd3,
        CFG_KEY_WORD3 = 3'd4
    } t_cfg_idx;

    typedef logic [NUM_RND:0][127:0] t_rk_arr;

    typedef struct packed {
        logic act;   // round is used for this key size
        logic last;  // final round, no column mix
    } t_rnd_ctl;

    // Forward S-box, entry 0 in the top byte.
    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [2047:0] build_inv_sbox();
        logic [2047:0] t;
        logic [7:0]    v;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            v = SBOX_TBL[(255 - i) * 8 +: 8];
            t[{~v, 3'b000} +: 8] = 8'(i);
        end
        return t;
    endfunction

    localparam logic [2047:0] INV_SBOX_TBL = build_inv_sbox();

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte i of the state sits at bits [127-8i -: 8].
    function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic dec);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[8 * i +: 8] = dec ? inv_sbox(s[8 * i +: 8]) : sbox(s[8 * i +: 8]);
        end
        return o;
    endfunction

    function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic dec);
        logic [127:0] o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (dec) begin
                    o[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c - r) & 3)) -: 8];
                end else begin
                    o[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8];
                end
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] col_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            o[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return o;
    endfunction

    // Multiplies by 9, 11, 13 and 14, packed {m9, m11, m13, m14}.
    function automatic logic [31:0] inv_mults(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
    endfunction

    function automatic logic [127:0] col_unmix(input logic [127:0] s);
        logic [127:0] o;
        logic [31:0]  m0, m1, m2, m3;
        for (int c = 0; c < 4; c++) begin
            m0 = inv_mults(s[127 - 32 * c -: 8]);
            m1 = inv_mults(s[119 - 32 * c -: 8]);
            m2 = inv_mults(s[111 - 32 * c -: 8]);
            m3 = inv_mults(s[103 - 32 * c -: 8]);
            // fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14
            o[127 - 32 * c -: 8] = m0[7:0] ^ m1[23:16] ^ m2[15:8] ^ m3[31:24];
            o[119 - 32 * c -: 8] = m0[31:24] ^ m1[7:0] ^ m2[23:16] ^ m3[15:8];
            o[111 - 32 * c -: 8] = m0[15:8] ^ m1[31:24] ^ m2[7:0] ^ m3[23:16];
            o[103 - 32 * c -: 8] = m0[23:16] ^ m1[15:8] ^ m2[31:24] ^ m3[7:0];
        end
        return o;
    endfunction

endpackage

@@ design/aes_block_cipher_unit.sv @@
// Top level of the pipelined AES-128/192/256 encrypt and decrypt unit.
//
// Usage:
//  - Input stream (i_s_*): one 128-bit block per transfer; tuser selects
//    encrypt (0) or decrypt (1). Output stream (o_m_*): the result block.
//  - Key and key size are written through the cfg port while no block is
//    in flight. Each write restarts the key expansion, which produces one
//    schedule word per cycle. o_s_tready stays low until it finishes.
//  - Reset clears the key registers to zero and runs the same expansion
//    for the all-zero 128-bit key before the first transfer.
//  - The latency is the same for every key size: an entry stage for the
//    first key add, then 14 round stages; stages past the last round pass
//    the state through.
//  - Throughput is one block per cycle. When the receiver holds tready low
//    while a result waits, the whole pipeline freezes in place and
//    o_s_tready drops the same cycle; nothing is dropped or duplicated.
module aes_block_cipher_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,   // [63:0] block_hi, [127:64] block_lo
    input  logic          i_s_tuser,   // [0] req_type
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [127:0]  o_m_tdata    // [63:0] result_hi, [127:64] result_lo
);

    localparam int NR = aesbc_pkg::NUM_RND;

    aesbc_pkg::t_rk_arr ek, dk;
    logic [3:0]         nr;
    logic               ks_busy;

    logic               pipe_en;
    logic               s_accept;

    logic               r_vld0;
    logic               r_dec0;
    logic [127:0]       r_st0;

    logic               w_vld [NR + 1];
    logic               w_dec [NR + 1];
    logic [127:0]       w_st  [NR + 1];

    aesbc_key_sched u_ks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ek       (ek),
        .o_dk       (dk),
        .o_nr       (nr),
        .o_busy     (ks_busy)
    );

    // The pipeline moves as a whole unless the last stage holds an untaken result.
    assign pipe_en    = !w_vld[NR] || i_m_tready;
    assign o_s_tready = pipe_en && !ks_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Entry stage: initial key add. Internal byte 0 is the MSB of block_hi.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (pipe_en) begin
            r_vld0 <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dec0 <= i_s_tuser;
            r_st0  <= {i_s_tdata[63:0], i_s_tdata[127:64]} ^ (i_s_tuser ? dk[0] : ek[0]);
        end
    end

    assign w_vld[0] = r_vld0;
    assign w_dec[0] = r_dec0;
    assign w_st[0]  = r_st0;

    for (genvar g = 1; g <= NR; g++) begin : g_rnd
        aesbc_pkg::t_rnd_ctl ctl;

        assign ctl.act  = (4'(g) <= nr);
        assign ctl.last = (4'(g) == nr);

        aesbc_round u_rnd (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (pipe_en),
            .i_vld    (w_vld[g - 1]),
            .i_dec    (w_dec[g - 1]),
            .i_ctl    (ctl),
            .i_state  (w_st[g - 1]),
            .i_rkey_e (ek[g]),
            .i_rkey_d (dk[g]),
            .o_vld    (w_vld[g]),
            .o_dec    (w_dec[g]),
            .o_state  (w_st[g])
        );
    end

    assign o_m_tvalid = w_vld[NR];
    assign o_m_tdata  = {w_st[NR][63:0], w_st[NR][127:64]};

endmodule

@@ design/aesbc_key_sched.sv @@
// Key registers and iterative key expansion, one schedule word per cycle.
module aesbc_key_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output aesbc_pkg::t_rk_arr   o_ek,
    output aesbc_pkg::t_rk_arr   o_dk,
    output logic [3:0]           o_nr,
    output logic                 o_busy
);

    logic [1:0]  r_mode;
    logic [63:0] r_kw0, r_kw1, r_kw2, r_kw3;
    logic        r_busy;
    logic [5:0]  r_idx;
    logic [2:0]  r_pos;
    logic [7:0]  r_rcon;
    logic [31:0] r_win [8];
    aesbc_pkg::t_rk_arr r_ek, r_dk;

    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [255:0] key_all;
    logic [31:0]  tmp;
    logic [31:0]  n_word;
    logic         restart;
    logic [3:0]   rnd;

    always_comb begin
        case (r_mode)
            2'd0:    begin nk = 4'd4; nr = 4'd10; end
            2'd1:    begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
    end

    assign key_all = {r_kw0, r_kw1, r_kw2, r_kw3};
    assign rnd     = r_idx[5:2];

    always_comb begin
        tmp = r_win[0];
        if (r_pos == 3'd0) begin
            tmp = aesbc_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_pos == 3'd4) begin
            tmp = aesbc_pkg::sub_word(tmp);
        end
        if (r_idx < {2'b00, nk}) begin
            n_word = key_all[{~r_idx[2:0], 5'b00000} +: 32];
        end else begin
            n_word = r_win[3'(nk - 4'd1)] ^ tmp;
        end
    end

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                aesbc_pkg::CFG_KEY_SIZE,
                aesbc_pkg::CFG_KEY_WORD0,
                aesbc_pkg::CFG_KEY_WORD1,
                aesbc_pkg::CFG_KEY_WORD2,
                aesbc_pkg::CFG_KEY_WORD3: restart = 1'b1;
                default:                  restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_kw0  <= '0;
            r_kw1  <= '0;
            r_kw2  <= '0;
            r_kw3  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aesbc_pkg::CFG_KEY_SIZE:  r_mode <= i_cfg_data[1:0];
                aesbc_pkg::CFG_KEY_WORD0: r_kw0  <= i_cfg_data;
                aesbc_pkg::CFG_KEY_WORD1: r_kw1  <= i_cfg_data;
                aesbc_pkg::CFG_KEY_WORD2: r_kw2  <= i_cfg_data;
                aesbc_pkg::CFG_KEY_WORD3: r_kw3  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // expansion sequencer: restarts on reset and on every key register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_pos  <= '0;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_idx <= r_idx + 6'd1;
            r_pos <= ({1'b0, r_pos} == nk - 4'd1) ? 3'd0 : r_pos + 3'd1;
            if (r_pos == 3'd0 && r_idx >= {2'b00, nk}) begin
                r_rcon <= aesbc_pkg::xtime(r_rcon);
            end
            if (r_idx == {nr, 2'b11}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !restart) begin
            r_win[0] <= n_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k - 1];
            end
            r_ek[rnd][{~r_idx[1:0], 5'b00000} +: 32]      <= n_word;
            r_dk[nr - rnd][{~r_idx[1:0], 5'b00000} +: 32] <= n_word;
        end
    end

    assign o_ek   = r_ek;
    assign o_dk   = r_dk;
    assign o_nr   = nr;
    assign o_busy = r_busy;

endmodule

@@ design/aesbc_round.sv @@
// One registered cipher round, forward or inverse, or a pass stage.
module aesbc_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic                 i_dec,
    input  aesbc_pkg::t_rnd_ctl  i_ctl,
    input  logic [127:0]         i_state,
    input  logic [127:0]         i_rkey_e,
    input  logic [127:0]         i_rkey_d,
    output logic                 o_vld,
    output logic                 o_dec,
    output logic [127:0]         o_state
);

    logic         r_vld;
    logic         r_dec;
    logic [127:0] r_state;

    logic [127:0] sr;
    logic [127:0] enc_out;
    logic [127:0] dec_x;
    logic [127:0] dec_out;
    logic [127:0] n_state;

    // byte substitution and row shift commute, so both directions share them
    always_comb begin
        sr      = aesbc_pkg::row_rotate(aesbc_pkg::byte_sub(i_state, i_dec), i_dec);
        enc_out = (i_ctl.last ? sr : aesbc_pkg::col_mix(sr)) ^ i_rkey_e;
        dec_x   = sr ^ i_rkey_d;
        dec_out = i_ctl.last ? dec_x : aesbc_pkg::col_unmix(dec_x);
        if (!i_ctl.act) begin
            n_state = i_state;
        end else if (i_dec) begin
            n_state = dec_out;
        end else begin
            n_state = enc_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec   <= i_dec;
            r_state <= n_state;
        end
    end

    assign o_vld   = r_vld;
    assign o_dec   = r_dec;
    assign o_state = r_state;

endmodule

@@ design/aesbc_checker.sv @@
// Port-level checks of the cipher unit, bound to the top level.
`include "aes_block_cipher_unit_assert.svh"

module aesbc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_we,
    input logic [2:0]    i_cfg_idx,
    input logic          i_s_tready,
    input logic          i_m_tvalid,
    input logic          i_m_tready,
    input logic [127:0]  i_m_tdata
);

    logic cfg_key_wr;

    assign cfg_key_wr = i_cfg_we && (i_cfg_idx <= aesbc_pkg::CFG_KEY_WORD3);

    // a stalled result keeps its value
    `ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed under stall")
    // key expansion runs after reset, so no block is taken right away
    `ASSERT_NEXT_ALWAYS(a_rst_busy, !i_rst_n, !i_s_tready, "input ready right after reset")
    // reset empties the pipeline
    `ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !i_m_tvalid, "output valid right after reset")
    // a key register write restarts the expansion
    `ASSERT_NEXT(a_cfg_busy, cfg_key_wr, !i_s_tready, "input ready right after key write")

endmodule

bind aes_block_cipher_unit aesbc_checker u_aesbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .i_cfg_idx  (i_cfg_idx),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
